@@ hw/rtl/bmbt_pkg.sv @@
`timescale 1ns / 1ps
// bmbt_pkg: shared types, codes and the neighborhood rule table of the boundary tracer
// depends on nothing; imported by binary_mask_boundary_tracer and tb
package bmbt_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int CFG_W          = 9;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_START = 2'd1,
		OP_STEP  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		MV_LEFT  = 2'd0,
		MV_DOWN  = 2'd1,
		MV_RIGHT = 2'd2,
		MV_UP    = 2'd3
	} move_t;

	typedef enum logic [2:0] {
		ST_ACK    = 3'd0,
		ST_POINT  = 3'd1,
		ST_CLOSED = 3'd2,
		ST_EMPTY  = 3'd3,
		ST_LOST   = 3'd4,
		ST_IDLE   = 3'd5
	} status_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_index_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WR,
		S_SC_ROW,
		S_SC_CHUNK,
		S_SC_BELOW,
		S_ST0,
		S_ST1,
		S_ST2,
		S_ST3,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic l;
		logic r;
		logic u;
		logic d;
		logic lu;
		logic ru;
		logic ld;
		logic rd;
	} nbhd_t;

	typedef struct packed {
		logic  hit;
		move_t m0;
		move_t m1;
	} rule_t;

	// ordered case rules, first match wins
	function automatic rule_t classify(input nbhd_t n);
		rule_t res;
		res.hit = 1'b1;
		res.m0  = MV_UP;
		res.m1  = MV_DOWN;
		if (((!n.l || !n.r) && (n.u && n.d)) || (n.r && !n.ru && !n.rd) ||
				(n.l && !n.lu && !n.ld)) begin
			res.m0 = MV_UP;    res.m1 = MV_DOWN;
		end else if (((!n.u || !n.d) && (n.l && n.r)) || (n.u && !n.ru && !n.lu) ||
				(n.d && !n.rd && !n.ld)) begin
			res.m0 = MV_LEFT;  res.m1 = MV_RIGHT;
		end else if (!n.u && !n.l) begin
			res.m0 = MV_DOWN;  res.m1 = MV_RIGHT;
		end else if (!n.u && !n.r) begin
			res.m0 = MV_DOWN;  res.m1 = MV_LEFT;
		end else if (!n.d && !n.l) begin
			res.m0 = MV_UP;    res.m1 = MV_RIGHT;
		end else if (!n.d && !n.r) begin
			res.m0 = MV_UP;    res.m1 = MV_LEFT;
		end else if (!n.ld) begin
			res.m0 = MV_LEFT;  res.m1 = MV_DOWN;
		end else if (!n.rd) begin
			res.m0 = MV_RIGHT; res.m1 = MV_DOWN;
		end else if (!n.lu) begin
			res.m0 = MV_LEFT;  res.m1 = MV_UP;
		end else if (!n.ru) begin
			res.m0 = MV_RIGHT; res.m1 = MV_UP;
		end else begin
			res.hit = 1'b0;
		end
		return res;
	endfunction

endpackage

@@ hw/rtl/binary_mask_boundary_tracer.sv @@
`timescale 1ns / 1ps
// binary_mask_boundary_tracer: mask row memory, start scan and contour walker
// depends on bmbt_pkg
//
// usage
//   input channel (in_valid/in_ready) carries one command per transfer: write a
//   pixel, start a trace, or step the trace. every command except the unused
//   code gives exactly one transfer on the output channel (out_valid/out_ready).
//   config port: cfg_write with cfg_index/cfg_data sets width and height;
//   the user must write it only while the block is idle; the block does not enforce it.
// steps from an accepted command to the result in the output register
//   write pixel: row read, modified row write back, result load
//   step: three sequential row reads of the single read port, then the move decision
//   step without trace or at the origin: no row read, result load only
//   start: rows scanned, then 16-bit chunks searched in the hit row, then the row below
//   the origin is read; one mask row is read per cycle while rows are scanned.
// one command is in flight at a time; in_ready is high whenever the
// sequencer is idle, even while a result still waits in the output register.
// if the receiver stalls, the finished result of the next command waits in
// the sequencer until the output register is free.
// reset clears the trace state and the output valid and sets width and height
// to 256; the mask memory is not cleared and holds garbage until written.
module binary_mask_boundary_tracer #(
	parameter int MAX_WIDTH  = bmbt_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bmbt_pkg::DEF_MAX_HEIGHT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// command channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 opcode,
	input  logic [7:0]                 pixel_x,
	input  logic [7:0]                 pixel_y,
	input  logic                       pixel_set,
	// result channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 point_x,
	output logic [7:0]                 point_y,
	output logic [2:0]                 status,
	// config write port
	input  logic                       cfg_write,
	input  logic                       cfg_index,
	input  logic [bmbt_pkg::CFG_W-1:0] cfg_data
);
	import bmbt_pkg::*;

	// stored columns and rows: coordinates never exceed 8 bits
	localparam int COLS = (MAX_WIDTH  < 256) ? MAX_WIDTH  : 256;
	localparam int ROWS = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
	localparam int CAW  = $clog2(COLS);
	localparam int RAW  = $clog2(ROWS);
	// start search looks at 16 columns of the hit row per cycle
	localparam int CW   = 16;
	localparam int NCH  = (COLS + CW - 1) / CW;
	localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PADW = NCH * CW;

	// mask memory, one row per entry
	logic [COLS-1:0] mask_mem [ROWS];
	logic [COLS-1:0] rdata_q;
	logic            rd_en;
	logic [RAW-1:0]  rd_addr;
	logic            wr_en;
	logic [COLS-1:0] wr_data;

	state_t state_q, state_d;

	// control registers
	logic [8:0]     width_q, height_q;
	logic           active_q;
	logic [7:0]     walker_x_q, walker_y_q;
	logic [7:0]     origin_x_q, origin_y_q;
	move_t          prev_q;
	logic [7:0]     scan_y_q;
	logic [CHW-1:0] chunk_q;
	logic           out_valid_q;

	// payload registers
	logic [7:0]      res_x_q, res_y_q;
	status_t         res_st_q;
	logic            set_q;
	logic [2:0]      win_up_q, win_mid_q, win_dn_q;
	logic [PADW-1:0] row_q;
	logic [7:0]      point_x_q, point_y_q;
	status_t         status_q;

	// derived values
	logic [8:0]      w_eff, h_eff;
	logic            wr_in_range, dims_small, at_origin, emit_go;
	logic [8:0]      y_c, y_up, y_dn, x_c;
	logic            up_ok, mid_ok, dn_ok;
	logic [8:0]      scan_next;
	logic            scan_last;
	logic [PADW-1:0] row_pad, interior;
	logic            row_hit;
	logic [CW-1:0]   chunk_bits;
	logic [3:0]      chunk_pos;
	logic            below_set;
	nbhd_t           nb;
	rule_t           rule;
	move_t           rev_mv, mv;
	logic            blocked, step_lost;
	logic [7:0]      next_x, next_y;

	// 3-pixel window {right, center, left} of a row around column x, zero outside the image
	function automatic logic [2:0] win3(input logic [COLS-1:0] row, input logic [7:0] x,
			input logic [8:0] w);
		logic [8:0] xl, xc, xr;
		logic [2:0] b;
		xc   = {1'b0, x};
		xl   = xc - 9'd1;
		xr   = xc + 9'd1;
		b[0] = (x != 8'd0) && (xl < w) && row[xl[CAW-1:0]];
		b[1] = (xc < w) && row[xc[CAW-1:0]];
		b[2] = (xr < w) && row[xr[CAW-1:0]];
		return b;
	endfunction

	// lowest set bit of a 16-bit chunk
	function automatic logic [3:0] first16(input logic [CW-1:0] v);
		logic [3:0] p;
		p = 4'd0;
		for (int i = CW - 1; i >= 0; i--) begin
			if (v[i]) begin
				p = 4'(i);
			end
		end
		return p;
	endfunction

	assign w_eff = (width_q  > 9'(COLS)) ? 9'(COLS) : width_q;
	assign h_eff = (height_q > 9'(ROWS)) ? 9'(ROWS) : height_q;

	assign wr_in_range = ({1'b0, pixel_x} < 9'(COLS)) && ({1'b0, pixel_y} < 9'(ROWS));
	assign dims_small  = (w_eff < 9'd3) || (h_eff < 9'd3);
	assign at_origin   = (walker_x_q == origin_x_q) && (walker_y_q == origin_y_q);
	assign emit_go     = !out_valid_q || out_ready;

	// neighbor rows of the walker and whether they lie inside the image
	assign x_c    = {1'b0, walker_x_q};
	assign y_c    = {1'b0, walker_y_q};
	assign y_up   = y_c - 9'd1;
	assign y_dn   = y_c + 9'd1;
	assign up_ok  = (walker_y_q != 8'd0) && (y_up < h_eff);
	assign mid_ok = y_c < h_eff;
	assign dn_ok  = y_dn < h_eff;

	// start scan: interior columns 1 .. W-2 of the row just read
	assign scan_next = {1'b0, scan_y_q} + 9'd1;
	assign scan_last = ({1'b0, scan_y_q} + 9'd2) >= h_eff;
	assign row_pad   = PADW'(rdata_q);
	always_comb begin
		for (int i = 0; i < PADW; i++) begin
			interior[i] = row_pad[i] && (i >= 1) && ((9'(i) + 9'd1) < w_eff);
		end
	end
	assign row_hit    = |interior;
	assign chunk_bits = row_q[{chunk_q, 4'b0000} +: CW];
	assign chunk_pos  = first16(chunk_bits);
	assign below_set  = rdata_q[origin_x_q[CAW-1:0]];

	// step decision from the three registered windows
	assign nb.l   = win_mid_q[0];
	assign nb.r   = win_mid_q[2];
	assign nb.u   = win_up_q[1];
	assign nb.d   = win_dn_q[1];
	assign nb.lu  = win_up_q[0];
	assign nb.ru  = win_up_q[2];
	assign nb.ld  = win_dn_q[0];
	assign nb.rd  = win_dn_q[2];
	assign rule   = classify(nb);
	assign rev_mv = move_t'(prev_q ^ 2'b10);
	assign mv     = (rule.m0 != rev_mv) ? rule.m0 : rule.m1;

	always_comb begin
		blocked = 1'b0;
		next_x  = walker_x_q;
		next_y  = walker_y_q;
		case (mv)
			MV_LEFT: begin
				blocked = walker_x_q == 8'd0;
				next_x  = walker_x_q - 8'd1;
			end
			MV_DOWN: begin
				blocked = y_dn >= h_eff;
				next_y  = walker_y_q + 8'd1;
			end
			MV_RIGHT: begin
				blocked = (x_c + 9'd1) >= w_eff;
				next_x  = walker_x_q + 8'd1;
			end
			MV_UP: begin
				blocked = walker_y_q == 8'd0;
				next_y  = walker_y_q - 8'd1;
			end
			default: begin
				blocked = 1'b1;
			end
		endcase
	end
	assign step_lost = !rule.hit || blocked;

	// pixel write: read-modify-write of one row; the sequencer never overlaps
	// a row read with the write back, so no forwarding is needed
	always_comb begin
		for (int i = 0; i < COLS; i++) begin
			wr_data[i] = (9'(i) == {1'b0, res_x_q}) ? set_q : rdata_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mask_mem[res_y_q[RAW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mask_mem[rd_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (opcode_t'(opcode))
						OP_WRITE: begin
							if (wr_in_range) begin
								rd_en   = 1'b1;
								rd_addr = pixel_y[RAW-1:0];
								state_d = S_WR;
							end else begin
								state_d = S_EMIT;
							end
						end
						OP_START: begin
							if (dims_small) begin
								state_d = S_EMIT;
							end else begin
								rd_en   = 1'b1;
								rd_addr = RAW'(1);
								state_d = S_SC_ROW;
							end
						end
						OP_STEP: begin
							if (!active_q || at_origin) begin
								state_d = S_EMIT;
							end else begin
								rd_en   = up_ok;
								rd_addr = y_up[RAW-1:0];
								state_d = S_ST0;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_WR: begin
				wr_en   = 1'b1;
				state_d = S_EMIT;
			end
			S_SC_ROW: begin
				if (row_hit) begin
					state_d = S_SC_CHUNK;
				end else if (scan_last) begin
					state_d = S_EMIT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = scan_next[RAW-1:0];
				end
			end
			S_SC_CHUNK: begin
				if (|chunk_bits) begin
					rd_en   = 1'b1;
					rd_addr = scan_next[RAW-1:0];
					state_d = S_SC_BELOW;
				end
			end
			S_SC_BELOW: begin
				state_d = S_EMIT;
			end
			S_ST0: begin
				rd_en   = mid_ok;
				rd_addr = y_c[RAW-1:0];
				state_d = S_ST1;
			end
			S_ST1: begin
				rd_en   = dn_ok;
				rd_addr = y_dn[RAW-1:0];
				state_d = S_ST2;
			end
			S_ST2: begin
				state_d = S_ST3;
			end
			S_ST3: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (emit_go) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_ready = state_q == S_IDLE;

	// control state: config, trace, scan counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 9'd256;
			height_q    <= 9'd256;
			active_q    <= 1'b0;
			walker_x_q  <= 8'd0;
			walker_y_q  <= 8'd0;
			origin_x_q  <= 8'd0;
			origin_y_q  <= 8'd0;
			prev_q      <= MV_LEFT;
			scan_y_q    <= 8'd0;
			chunk_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (reg_index_t'(cfg_index))
					REG_WIDTH:  width_q  <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (opcode_t'(opcode))
							OP_START: begin
								if (dims_small) begin
									active_q <= 1'b0;
								end else begin
									scan_y_q <= 8'd1;
								end
							end
							OP_STEP: begin
								if (active_q && at_origin) begin
									active_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				S_SC_ROW: begin
					if (row_hit) begin
						chunk_q <= '0;
					end else if (scan_last) begin
						active_q <= 1'b0;
					end else begin
						scan_y_q <= scan_next[7:0];
					end
				end
				S_SC_CHUNK: begin
					if (|chunk_bits) begin
						origin_x_q <= 8'({chunk_q, chunk_pos});
						origin_y_q <= scan_y_q;
					end else begin
						chunk_q <= chunk_q + 1'b1;
					end
				end
				S_SC_BELOW: begin
					// first move: right if the pixel below the origin is clear, else down
					active_q <= 1'b1;
					if (!below_set) begin
						walker_x_q <= origin_x_q + 8'd1;
						walker_y_q <= origin_y_q;
						prev_q     <= MV_RIGHT;
					end else begin
						walker_x_q <= origin_x_q;
						walker_y_q <= origin_y_q + 8'd1;
						prev_q     <= MV_DOWN;
					end
				end
				S_ST3: begin
					if (step_lost) begin
						active_q <= 1'b0;
					end else begin
						walker_x_q <= next_x;
						walker_y_q <= next_y;
						prev_q     <= mv;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// result payload, windows and output register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (opcode_t'(opcode))
						OP_WRITE: begin
							res_x_q  <= pixel_x;
							res_y_q  <= pixel_y;
							res_st_q <= ST_ACK;
							set_q    <= pixel_set;
						end
						OP_START: begin
							res_x_q  <= 8'd0;
							res_y_q  <= 8'd0;
							res_st_q <= ST_EMPTY;
						end
						OP_STEP: begin
							if (!active_q) begin
								res_x_q  <= 8'd0;
								res_y_q  <= 8'd0;
								res_st_q <= ST_IDLE;
							end else begin
								res_x_q  <= origin_x_q;
								res_y_q  <= origin_y_q;
								res_st_q <= ST_CLOSED;
							end
						end
						default: ;
					endcase
				end
			end
			S_SC_ROW: begin
				row_q <= interior;
			end
			S_SC_BELOW: begin
				res_x_q  <= origin_x_q;
				res_y_q  <= origin_y_q;
				res_st_q <= ST_POINT;
			end
			S_ST0: begin
				win_up_q <= up_ok ? win3(rdata_q, walker_x_q, w_eff) : 3'b000;
			end
			S_ST1: begin
				win_mid_q <= mid_ok ? win3(rdata_q, walker_x_q, w_eff) : 3'b000;
			end
			S_ST2: begin
				win_dn_q <= dn_ok ? win3(rdata_q, walker_x_q, w_eff) : 3'b000;
			end
			S_ST3: begin
				res_x_q  <= walker_x_q;
				res_y_q  <= walker_y_q;
				res_st_q <= step_lost ? ST_LOST : ST_POINT;
			end
			S_EMIT: begin
				if (emit_go) begin
					point_x_q <= res_x_q;
					point_y_q <= res_y_q;
					status_q  <= res_st_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign point_x   = point_x_q;
	assign point_y   = point_y_q;
	assign status    = status_q;

	// a new result is only ever loaded from the emit state
	a_load_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_EMIT)
		else $error("output valid rose outside the emit state");

	// row write back directly follows the accepted write command
	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR |-> $past(state_q) == S_IDLE && $past(opcode) == OP_WRITE)
		else $error("row write back without a preceding write transfer");

	// a found origin always starts a trace and reports it next
	a_start_arms: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SC_BELOW |=> active_q && state_q == S_EMIT)
		else $error("origin found but trace not armed");

	// an active walker always addresses stored columns and rows
	a_walker_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> ({1'b0, walker_x_q} < 9'(COLS)) && ({1'b0, walker_y_q} < 9'(ROWS)))
		else $error("walker outside the mask store");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for binary_mask_boundary_tracer, own contour predictor and scoreboard
// depends on bmbt_pkg and binary_mask_boundary_tracer; needs no files or arguments
module tb;
	import bmbt_pkg::*;

	localparam int IMG_MAX       = 256;
	localparam int RANDOM_ITEMS  = 1750;
	localparam int STEP_CAP      = 60;
	// longest command is a start scan
	localparam int SETTLE_CYCLES = 300;
	// full store clear plus every command at its worst gap, stall and scan time, times several
	localparam int CYCLE_LIMIT   = 4000000;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		status_t    st;
	} contour_result_t;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
	} pixel_pos_t;

	// clock, reset and dut ports, all inputs known from time zero
	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [1:0] opcode    = OP_WRITE;
	logic [7:0] pixel_x   = '0;
	logic [7:0] pixel_y   = '0;
	logic       pixel_set = 1'b0;
	logic       out_ready = 1'b1;
	logic       cfg_write = 1'b0;
	logic       cfg_index = REG_WIDTH;
	logic [CFG_W-1:0] cfg_data = 9'd256;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] point_x;
	logic [7:0] point_y;
	logic [2:0] status;

	// predictor copy of the block: mask store, size registers and walker
	bit [IMG_MAX-1:0] mask_copy [IMG_MAX];
	logic [CFG_W-1:0] width_cfg  = 9'd256;
	logic [CFG_W-1:0] height_cfg = 9'd256;
	int    walk_x, walk_y, org_x, org_y;
	move_t last_move = MV_LEFT;
	bit    tracing   = 1'b0;

	// results still owed by the block, oldest first
	contour_result_t expected_results[$];
	contour_result_t want;
	// pixels set by the stimulus, cleared again later
	pixel_pos_t lit_pixels[$];

	// pacing controls and bookkeeping
	bit tx_gaps   = 1'b0;
	bit rx_stalls = 1'b0;
	int hold_cnt  = 0;
	int cycle_count    = 0;
	int fail_count     = 0;
	int items_sent     = 0;
	int results_seen   = 0;
	int closed_traces  = 0;
	int lost_traces    = 0;
	int empty_scans    = 0;
	int idle_steps     = 0;
	int cleared_pixels = 0;

	binary_mask_boundary_tracer dut (
		.clk, .arst_n,
		.in_valid, .in_ready, .opcode, .pixel_x, .pixel_y, .pixel_set,
		.out_valid, .out_ready, .point_x, .point_y, .status,
		.cfg_write, .cfg_index, .cfg_data
	);

	always #10 clk = ~clk;

	// size register as the block uses it, clipped to the store
	function automatic int clip_dim(logic [CFG_W-1:0] r);
		return (r > IMG_MAX) ? IMG_MAX : int'(r);
	endfunction

	function automatic int fit(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// anything outside the configured image reads as clear
	function automatic bit mask_at(int x, int y);
		if (x < 0 || y < 0 || x >= clip_dim(width_cfg) || y >= clip_dim(height_cfg))
			return 1'b0;
		return mask_copy[y][x];
	endfunction

	// neighborhood rules in priority order; returns 0 when nothing matches
	function automatic bit pick_moves(int x, int y, output move_t m0, output move_t m1);
		bit l, r, u, d, lu, ru, ld, rd;
		l  = mask_at(x - 1, y);
		r  = mask_at(x + 1, y);
		u  = mask_at(x, y - 1);
		d  = mask_at(x, y + 1);
		lu = mask_at(x - 1, y - 1);
		ru = mask_at(x + 1, y - 1);
		ld = mask_at(x - 1, y + 1);
		rd = mask_at(x + 1, y + 1);
		m0 = MV_UP;
		m1 = MV_DOWN;
		// vertical edge through the walker
		if (((!l || !r) && u && d) || (r && !ru && !rd) || (l && !lu && !ld))
			return 1'b1;
		// horizontal edge through the walker
		if (((!u || !d) && l && r) || (u && !ru && !lu) || (d && !rd && !ld)) begin
			m0 = MV_LEFT;  m1 = MV_RIGHT;
		// outer corners
		end else if (!u && !l) begin
			m0 = MV_DOWN;  m1 = MV_RIGHT;
		end else if (!u && !r) begin
			m0 = MV_DOWN;  m1 = MV_LEFT;
		end else if (!d && !l) begin
			m0 = MV_UP;    m1 = MV_RIGHT;
		end else if (!d && !r) begin
			m0 = MV_UP;    m1 = MV_LEFT;
		// inner corners, diagonal gaps
		end else if (!ld) begin
			m0 = MV_LEFT;  m1 = MV_DOWN;
		end else if (!rd) begin
			m0 = MV_RIGHT; m1 = MV_DOWN;
		end else if (!lu) begin
			m0 = MV_LEFT;  m1 = MV_UP;
		end else if (!ru) begin
			m0 = MV_RIGHT; m1 = MV_UP;
		end else begin
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// advances the predictor by one command and queues the result it owes
	function automatic void predict_command(opcode_t op, logic [7:0] x, logic [7:0] y,
			logic val);
		contour_result_t res;
		int w, h, sx, sy, nx, ny;
		bit found;
		move_t m0, m1, mv;
		logic [1:0] back_code;
		w = clip_dim(width_cfg);
		h = clip_dim(height_cfg);
		res = '0;
		case (op)
			OP_WRITE: begin
				// stored even outside the current image
				mask_copy[y][x] = val;
				res.x = x;
				res.y = y;
				res.st = ST_ACK;
			end
			OP_START: begin
				// raster scan of the interior only, border rows and columns skipped
				found = 1'b0;
				for (sy = 1; sy < h - 1 && !found; sy++)
					for (sx = 1; sx < w - 1 && !found; sx++)
						if (mask_at(sx, sy)) begin
							found = 1'b1;
							org_x = sx;
							org_y = sy;
						end
				if (found) begin
					if (!mask_at(org_x, org_y + 1)) begin
						walk_x = org_x + 1;  walk_y = org_y;  last_move = MV_RIGHT;
					end else begin
						walk_x = org_x;  walk_y = org_y + 1;  last_move = MV_DOWN;
					end
					tracing = 1'b1;
					res.x = 8'(org_x);
					res.y = 8'(org_y);
					res.st = ST_POINT;
				end else begin
					tracing = 1'b0;
					res.st = ST_EMPTY;
					empty_scans++;
				end
			end
			OP_STEP: begin
				if (!tracing) begin
					res.st = ST_IDLE;
					idle_steps++;
				end else if (walk_x == org_x && walk_y == org_y) begin
					tracing = 1'b0;
					res.x = 8'(org_x);
					res.y = 8'(org_y);
					res.st = ST_CLOSED;
					closed_traces++;
				end else begin
					res.x = 8'(walk_x);
					res.y = 8'(walk_y);
					res.st = ST_POINT;
					if (!pick_moves(walk_x, walk_y, m0, m1)) begin
						res.st = ST_LOST;
					end else begin
						// never turn straight back
						back_code = last_move + 2'd2;
						mv = (m0 != back_code) ? m0 : m1;
						nx = walk_x;
						ny = walk_y;
						case (mv)
							MV_LEFT:  nx--;
							MV_DOWN:  ny++;
							MV_RIGHT: nx++;
							default:  ny--;
						endcase
						if (nx < 0 || ny < 0 || nx >= w || ny >= h) begin
							res.st = ST_LOST;
						end else begin
							walk_x = nx;
							walk_y = ny;
							last_move = mv;
						end
					end
					if (res.st == ST_LOST) begin
						tracing = 1'b0;
						lost_traces++;
					end
				end
			end
			default: return;  // unused code, no result
		endcase
		expected_results.push_back(res);
	endfunction

	// most idle stretches short, a few long
	function automatic int idle_span();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// cycle counter and timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycle_count,
				expected_results.size());
			$display("binary_mask_boundary_tracer test failed");
			$finish;
		end
	end

	// receiver: ready stretches alternate with stalls when stalls are enabled
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (!rx_stalls) begin
			out_ready <= 1'b1;
		end else if ($urandom_range(0, 2) == 0) begin
			out_ready <= 1'b0;
			hold_cnt <= idle_span() - 1;
		end else begin
			out_ready <= 1'b1;
			hold_cnt <= $urandom_range(0, 6);
		end
	end

	// scoreboard: each result transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("result with nothing owed: point_x %0d point_y %0d status %0d",
					point_x, point_y, status);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (point_x !== want.x) begin
					$error("point_x: expected %0d, got %0d", want.x, point_x);
					fail_count++;
				end
				if (point_y !== want.y) begin
					$error("point_y: expected %0d, got %0d", want.y, point_y);
					fail_count++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					fail_count++;
				end
			end
		end
	end

	// one command transfer; valid stays up until the block takes it
	task automatic send_cmd(opcode_t op, logic [7:0] x, logic [7:0] y, logic val);
		int gap;
		gap = (tx_gaps && $urandom_range(0, 2) == 0) ? idle_span() : 0;
		predict_command(op, x, y, val);
		if (op != OP_NONE)
			items_sent++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		pixel_x   <= x;
		pixel_y   <= y;
		pixel_set <= val;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic paint(int x, int y);
		pixel_pos_t p;
		p.x = 8'(x);
		p.y = 8'(y);
		lit_pixels.push_back(p);
		send_cmd(OP_WRITE, p.x, p.y, 1'b1);
	endtask

	task automatic clear_lit();
		pixel_pos_t p;
		while (lit_pixels.size() != 0) begin
			p = lit_pixels.pop_front();
			send_cmd(OP_WRITE, p.x, p.y, 1'b0);
		end
	endtask

	// all results in, then room for a command that gives none
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// size registers are only touched with the block idle
	task automatic set_image_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
		wait_drain();
		cfg_write <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_write <= 1'b0;
		width_cfg  = w;
		height_cfg = h;
	endtask

	task automatic step_until_done();
		int n;
		n = 0;
		while (tracing && n < STEP_CAP) begin
			send_cmd(OP_STEP, '0, '0, 1'b0);
			n++;
		end
	endtask

	// random command of any kind; writes often land next to the walker
	task automatic send_noise();
		opcode_t op;
		int x, y;
		logic val;
		op  = opcode_t'($urandom_range(0, 3));
		x   = $urandom_range(0, 255);
		y   = $urandom_range(0, 255);
		val = $urandom_range(0, 1);
		if (op == OP_WRITE && $urandom_range(0, 1) == 0) begin
			x = fit(walk_x + $urandom_range(0, 2) - 1, 0, 255);
			y = fit(walk_y + $urandom_range(0, 2) - 1, 0, 255);
		end
		if (op == OP_WRITE && val)
			paint(x, y);
		else
			send_cmd(op, 8'(x), 8'(y), val);
	endtask

	// every store entry written once, so no row is ever read undefined
	task automatic clear_mask_store();
		int x, y;
		for (y = 0; y < IMG_MAX; y++)
			for (x = 0; x < IMG_MAX; x++)
				send_cmd(OP_WRITE, 8'(x), 8'(y), 1'b0);
		cleared_pixels = items_sent;
		items_sent = 0;
	endtask

	// steps with no trace, empty scans, unused code, border pixels never found
	task automatic test_idle_and_empty();
		send_cmd(OP_STEP, '0, '0, 1'b0);
		send_cmd(OP_START, '0, '0, 1'b0);
		send_cmd(OP_NONE, 8'hff, 8'hff, 1'b1);
		send_cmd(OP_WRITE, 8'hff, 8'hff, 1'b1);
		send_cmd(OP_START, '0, '0, 1'b0);
		send_cmd(OP_WRITE, 8'hff, 8'hff, 1'b0);
	endtask

	// a 2x2 block walks round its edge and closes on the origin
	task automatic test_square_closure();
		paint(1, 1);
		paint(2, 1);
		paint(1, 2);
		paint(2, 2);
		send_cmd(OP_START, '0, '0, 1'b0);
		step_until_done();
		send_cmd(OP_STEP, '0, '0, 1'b0);
	endtask

	// walker starts inside a full 3x3 block, column 0 is never scanned,
	// so no rule matches and the trace is lost
	task automatic test_surrounded_lost();
		paint(0, 1);
		paint(0, 2);
		paint(0, 3);
		paint(1, 3);
		paint(2, 3);
		send_cmd(OP_START, '0, '0, 1'b0);
		send_cmd(OP_STEP, '0, '0, 1'b0);
	endtask

	// smallest image, then sizes under 3 and clipped sizes
	task automatic test_tiny_image();
		set_image_size(9'd3, 9'd3);
		send_cmd(OP_START, '0, '0, 1'b0);
		step_until_done();
		send_cmd(OP_STEP, '0, '0, 1'b0);
		set_image_size(9'd511, 9'd2);
		send_cmd(OP_START, '0, '0, 1'b0);
		set_image_size(9'd0, 9'd256);
		send_cmd(OP_START, '0, '0, 1'b0);
		send_cmd(OP_STEP, '0, '0, 1'b0);
		set_image_size(9'd256, 9'd256);
		clear_lit();
	endtask

	// one blob of overlapping rectangles, a trace over it, then mostly cleanup
	task automatic run_shape_trace();
		int w, h, bx, by, rw, rh, x0, y0, i, x, y;
		w = clip_dim(width_cfg);
		h = clip_dim(height_cfg);
		if (w > 0 && h > 0) begin
			bx = $urandom_range(0, w - 1);
			by = $urandom_range(0, h - 1);
			repeat ($urandom_range(1, 3)) begin
				rw = $urandom_range(1, (w < 5) ? w : 5);
				rh = $urandom_range(1, (h < 5) ? h : 5);
				x0 = fit(bx + $urandom_range(0, 4) - 2, 0, w - rw);
				y0 = fit(by + $urandom_range(0, 4) - 2, 0, h - rh);
				for (y = y0; y < y0 + rh; y++)
					for (x = x0; x < x0 + rw; x++)
						paint(x, y);
			end
			// occasional hole punched into the last rectangle
			if ($urandom_range(0, 3) == 0)
				send_cmd(OP_WRITE, 8'(x0 + $urandom_range(0, rw - 1)),
					8'(y0 + $urandom_range(0, rh - 1)), 1'b0);
		end
		repeat ($urandom_range(0, 2)) send_noise();
		send_cmd(OP_START, '0, '0, 1'b0);
		i = 0;
		while (tracing && i < STEP_CAP) begin
			// rare disturbance mid trace: restart, write, extra step or unused code
			if ($urandom_range(0, 39) == 0)
				send_noise();
			send_cmd(OP_STEP, '0, '0, 1'b0);
			i++;
		end
		if ($urandom_range(0, 2) == 0)
			send_cmd(OP_STEP, '0, '0, 1'b0);
		if ($urandom_range(0, 6) != 0)
			clear_lit();
	endtask

	// random phases: new size, new pacing, a few traces each
	task automatic test_random_traces();
		logic [CFG_W-1:0] w, h;
		while (items_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 19))
				0:       begin w = 256; h = 256; end
				1:       begin w = 3; h = 3; end
				2:       begin w = 3; h = $urandom_range(3, 256); end
				3:       begin w = $urandom_range(3, 256); h = 3; end
				4:       begin w = $urandom_range(257, 511); h = $urandom_range(3, 20); end
				5:       begin w = $urandom_range(0, 2); h = $urandom_range(3, 20); end
				6:       begin w = 256; h = $urandom_range(3, 24); end
				7:       begin w = $urandom_range(3, 24); h = 256; end
				default: begin w = $urandom_range(3, 40); h = $urandom_range(3, 40); end
			endcase
			set_image_size(w, h);
			tx_gaps   = ($urandom_range(0, 3) != 0);
			rx_stalls = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(2, 6)) run_shape_trace();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		clear_mask_store();
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		test_idle_and_empty();
		test_square_closure();
		test_surrounded_lost();
		test_tiny_image();
		test_random_traces();
		wait_drain();
		$display("covered %0d commands after a %0d-pixel store clear, %0d results checked",
			items_sent, cleared_pixels, results_seen);
		$display("traces: %0d closed, %0d lost, %0d empty scans, %0d steps with no trace",
			closed_traces, lost_traces, empty_scans, idle_steps);
		if (fail_count == 0)
			$display("binary_mask_boundary_tracer test passed");
		else
			$display("binary_mask_boundary_tracer test failed");
		$finish;
	end

endmodule
